### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the deque rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property with reset disable
`define DQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// checked property with no reset disable
`define DQ_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");

`else

`define DQ_ASSERT(lbl, clk, rst_n, prop)
`define DQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared widths, command codes and control types of the deque
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned CMD_W        = 3;
	localparam int unsigned STAT_W       = 2;
	localparam int unsigned CNT_OUT_W    = 11;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} dq_status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic load_out;
	} dq_ctrl_t;

endpackage

`default_nettype wire

### design/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// ring buffer memory, pointers, cached end words and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dq_datapath #(
	parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dq_pkg::dq_ctrl_t                      ctrl,
	input  logic        [dq_pkg::CMD_W-1:0]       command,
	input  logic signed [dq_pkg::DATA_W-1:0]      push_value,
	output logic signed [dq_pkg::DATA_W-1:0]      popped_value,
	output logic        [dq_pkg::STAT_W-1:0]      status,
	output logic        [dq_pkg::CNT_OUT_W-1:0]   entry_count,
	output logic                                  is_empty,
	output logic signed [dq_pkg::DATA_W-1:0]      front_value,
	output logic signed [dq_pkg::DATA_W-1:0]      back_value
);

	import dq_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	typedef enum logic [1:0] {
		FIX_NONE,
		FIX_FRONT,
		FIX_BACK
	} fix_t;

	// wraps base + off once into the ring
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, off};
		if (s >= (CW + 1)'(DEPTH)) begin
			s = s - (CW + 1)'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] back_q;

	logic [DATA_W-1:0] popped_s1;
	dq_status_t        status_s1;
	fix_t              fix_s1;

	logic              is_push_front;
	logic              is_push_back;
	logic              is_pop_front;
	logic              is_pop_back;
	logic              full;
	logic              empty;
	logic [PW-1:0]     head_dec;
	logic [CW-1:0]     off;
	logic [PW-1:0]     ring_idx;
	logic [PW-1:0]     mem_addr;
	logic              mem_we;
	logic [DATA_W-1:0] new_front;
	logic [DATA_W-1:0] new_back;
	logic [EW-1:0]     cnt_ext;

	always_comb begin
		is_push_front = (command == CMD_PUSH_FRONT);
		is_push_back  = (command == CMD_PUSH_BACK);
		is_pop_front  = (command == CMD_POP_FRONT);
		is_pop_back   = (command == CMD_POP_BACK);
		full          = (count_q == CW'(DEPTH));
		empty         = (count_q == '0);
		head_dec      = (head_q == '0) ? PW'(DEPTH - 1) : head_q - 1'b1;
		if (is_pop_front) begin
			off = CW'(1);
		end else if (is_pop_back) begin
			off = count_q - CW'(2);
		end else begin
			off = count_q;
		end
		ring_idx = ring_add(head_q, off);
		mem_addr = is_push_front ? head_dec : ring_idx;
		mem_we   = ctrl.accept && !full && (is_push_front || is_push_back);
	end

	// single-port ring memory, read data registered and held until the result loads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= push_value;
		end
		if (ctrl.accept) begin
			rd_q <= mem[mem_addr];
		end
	end

	// pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctrl.accept) begin
			if ((is_push_front || is_push_back) && !full) begin
				count_q <= count_q + 1'b1;
				if (is_push_front) begin
					head_q <= head_dec;
				end
			end else if ((is_pop_front || is_pop_back) && !empty) begin
				count_q <= count_q - 1'b1;
				if (is_pop_front) begin
					head_q <= ring_idx;
				end
			end
		end
	end

	// end words after the step, patched from the memory read
	always_comb begin
		new_front = (fix_s1 == FIX_FRONT) ? rd_q : front_q;
		new_back  = (fix_s1 == FIX_BACK) ? rd_q : back_q;
		cnt_ext   = EW'(count_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			popped_s1 <= '0;
			status_s1 <= STAT_OK;
			fix_s1    <= FIX_NONE;
			if (is_push_front || is_push_back) begin
				if (full) begin
					status_s1 <= STAT_FULL;
				end else begin
					if (is_push_front || empty) begin
						front_q <= push_value;
					end
					if (is_push_back || empty) begin
						back_q <= push_value;
					end
				end
			end else if (is_pop_front || is_pop_back) begin
				if (empty) begin
					status_s1 <= STAT_EMPTY;
				end else if (is_pop_front) begin
					popped_s1 <= front_q;
					fix_s1    <= FIX_FRONT;
				end else begin
					popped_s1 <= back_q;
					fix_s1    <= FIX_BACK;
				end
			end
		end
		if (ctrl.load_out) begin
			front_q      <= new_front;
			back_q       <= new_back;
			popped_value <= popped_s1;
			status       <= status_s1;
			entry_count  <= cnt_ext[CNT_OUT_W-1:0];
			is_empty     <= (count_q == '0);
			front_value  <= (count_q == '0) ? '0 : new_front;
			back_value   <= (count_q == '0) ? '0 : new_back;
		end
	end

	`DQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`DQ_ASSERT(a_head_bound, clk, arst_n, head_q < PW'(DEPTH - 1) || head_q == PW'(DEPTH - 1))
	`DQ_ASSERT(a_push_grows, clk, arst_n, (ctrl.accept && is_push_back && !full) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

### design/dq_controller.sv
// ----------------------------------------------------------------------------
// dq_controller
// item sequencing and result handshake of the deque
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dq_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output dq_pkg::dq_ctrl_t ctrl
);

	import dq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_free      = !out_valid_q || !out_stall;
		ctrl.accept   = in_valid && (state_q == ST_IDLE);
		ctrl.load_out = (state_q == ST_EXEC) && out_free;
		out_valid     = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DQ_ASSERT(a_accept_exec, clk, arst_n, ctrl.accept |=> (state_q == ST_EXEC))
	`DQ_ASSERT(a_load_valid, clk, arst_n, ctrl.load_out |=> out_valid_q)
	`DQ_ASSERT_ALWAYS(a_cmd_excl, clk, !(ctrl.accept && ctrl.load_out))

endmodule

`default_nettype wire

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit words held in a ring buffer memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one item: a command (none,
//   push front, push back, pop front, pop back) and a push value
//   output channel (out_valid / out_stall) returns exactly one result item
//   per input item: popped value, status, count, empty flag, front and back
//   result: once the input item is taken, the exec state loads its result
//   into the output register as soon as that register is free
//   a new item is taken only after the current one has loaded its result;
//   in the exec state the registered read of the single-port ring memory
//   supplies the new front or back word after a pop
//   receiver stall: a held result sits in the output register; the next
//   item is still taken, and its result waits until the register frees
//   reset: asynchronous, clears head pointer and count, so the queue starts
//   empty; memory contents need no clearing and no pass is run
//   a push to a full queue is dropped and reported with the full status
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
	parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic        [dq_pkg::CMD_W-1:0]     command,
	input  logic signed [dq_pkg::DATA_W-1:0]    push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dq_pkg::DATA_W-1:0]    popped_value,
	output logic        [dq_pkg::STAT_W-1:0]    status,
	output logic        [dq_pkg::CNT_OUT_W-1:0] entry_count,
	output logic                                is_empty,
	output logic signed [dq_pkg::DATA_W-1:0]    front_value,
	output logic signed [dq_pkg::DATA_W-1:0]    back_value
);

	import dq_pkg::*;

	// accept / load strobes from the sequencer
	dq_ctrl_t ctrl;

	// sequencer: idle -> exec, holds the result handshake
	dq_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	// ring memory, pointers, cached end words, result register
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.command      (command),
		.push_value   (push_value),
		.popped_value (popped_value),
		.status       (status),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.front_value  (front_value),
		.back_value   (back_value)
	);

endmodule

`default_nettype wire

### dv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// self-checking regression for the bounded deque: a local ring-buffer
// predictor computes the full result view for every accepted item, and each
// result leaving the block is compared field by field with the oldest one
// ----------------------------------------------------------------------------

module double_ended_queue_test;

	import dq_pkg::*;

	localparam int unsigned DEPTH      = dq_pkg::DEPTH_DEFAULT;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned SETTLE_CYC = 10;

	// command codes the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_NONE        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	// what the block reports after one item
	typedef struct packed {
		logic signed [DATA_W-1:0]    popped;
		dq_status_t                  stat;
		logic        [CNT_OUT_W-1:0] count;
		logic                        empty;
		logic signed [DATA_W-1:0]    front;
		logic signed [DATA_W-1:0]    back;
	} deque_view_t;

	// receiver stall styles
	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_BLOCKY
	} rx_mode_t;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        in_valid   = 1'b0;
	logic                        in_stall;
	logic        [CMD_W-1:0]     command    = CMD_NONE;
	logic signed [DATA_W-1:0]    push_value = '0;
	logic                        out_valid;
	logic                        out_stall  = 1'b0;
	logic signed [DATA_W-1:0]    popped_value;
	logic        [STAT_W-1:0]    status;
	logic        [CNT_OUT_W-1:0] entry_count;
	logic                        is_empty;
	logic signed [DATA_W-1:0]    front_value;
	logic signed [DATA_W-1:0]    back_value;

	// predictor state: ring of words, index of the front word, fill level
	logic signed [DATA_W-1:0] ring_words [DEPTH];
	int unsigned              ring_head = 0;
	int unsigned              ring_fill = 0;

	// views still owed by the block, oldest first
	deque_view_t predicted_views [$];

	int unsigned mismatch_count = 0;
	int unsigned burst_left     = 0;
	int unsigned idle_cycles    = 0;
	rx_mode_t    rx_mode        = RX_FREE;
	int unsigned rx_mode_left   = 0;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.status       (status),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor: applies one command to the local ring and returns the view
	// ------------------------------------------------------------------------
	function automatic deque_view_t apply_command(logic [CMD_W-1:0] cmd,
			logic signed [DATA_W-1:0] word);
		deque_view_t view;
		int unsigned tail_idx;
		view.popped = '0;
		view.stat   = STAT_OK;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					// full: word is dropped, state untouched
					view.stat = STAT_FULL;
				end else if (cmd == CMD_PUSH_FRONT) begin
					ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
					ring_words[ring_head] = word;
					ring_fill++;
				end else begin
					ring_words[(ring_head + ring_fill) % DEPTH] = word;
					ring_fill++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (ring_fill == 0) begin
					view.stat = STAT_EMPTY;
				end else if (cmd == CMD_POP_FRONT) begin
					view.popped = ring_words[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end else begin
					view.popped = ring_words[(ring_head + ring_fill - 1) % DEPTH];
					ring_fill--;
				end
			end
			// none and the spare codes leave everything alone
			default: ;
		endcase
		view.count = ring_fill[CNT_OUT_W-1:0];
		view.empty = (ring_fill == 0);
		if (ring_fill != 0) begin
			tail_idx   = (ring_head + ring_fill - 1) % DEPTH;
			view.front = ring_words[ring_head];
			view.back  = ring_words[tail_idx];
		end else begin
			view.front = '0;
			view.back  = '0;
		end
		return view;
	endfunction

	// random word, with the corner values mixed in now and then
	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(15, 0))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// weighted command pick; whatever is left over becomes a no-op item
	function automatic logic [CMD_W-1:0] pick_command(int unsigned push_pct,
			int unsigned pop_pct);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < push_pct)
			return $urandom_range(1, 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		if (roll < push_pct + pop_pct)
			return $urandom_range(1, 0) ? CMD_POP_FRONT : CMD_POP_BACK;
		if ($urandom_range(1, 0))
			return CMD_NONE;
		return CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
	endfunction

	// ------------------------------------------------------------------------
	// input side: drive at the falling edge, bursts with random gaps between
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] word);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			// a quarter of the bursts follow straight on, no gap at all
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= cmd;
		push_value <= word;
		// hold the item until the block takes it
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted_views.insert(predicted_views.size(), apply_command(cmd, word));
	endtask

	// stop sending and hold off until every owed result is back
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (predicted_views.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// output side: stall pattern changes between free, choppy and blocky
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= rx_mode_t'($urandom_range(2, 0));
			rx_mode_left <= $urandom_range(200, 20);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_CHOPPY: out_stall <= ($urandom_range(2, 0) == 0);
			RX_BLOCKY: out_stall <= ($urandom_range(7, 0) != 0);
			default:   out_stall <= 1'b0;
		endcase
	end

	task automatic compare_field(input string field_name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field_name, want, got);
			mismatch_count++;
		end
	endtask

	// every result taken is matched against the oldest owed view
	always @(posedge clk) begin : result_check
		deque_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_views.size() == 0) begin
				$error("result item arrived with nothing owed");
				mismatch_count++;
			end else begin
				want = predicted_views[0];
				predicted_views.delete(0);
				compare_field("popped_value", want.popped, popped_value);
				compare_field("status", want.stat, status);
				compare_field("entry_count", want.count, entry_count);
				compare_field("is_empty", want.empty, is_empty);
				compare_field("front_value", want.front, front_value);
				compare_field("back_value", want.back, back_value);
			end
		end
	end

	// watchdog: too long with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("double_ended_queue regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// empty pops, extremes, no-op codes, both ends, wrap below index zero
	task automatic test_directed();
		send_item(CMD_POP_FRONT, 32'sh1234_5678);
		send_item(CMD_POP_BACK, '1);
		send_item(CMD_NONE, 32'sh7fff_ffff);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			send_item(CMD_W'(c), rand_word());
		// push front from head zero wraps to the top of the ring
		send_item(CMD_PUSH_FRONT, 32'sh7fff_ffff);
		send_item(CMD_PUSH_BACK, 32'sh8000_0000);
		send_item(CMD_PUSH_FRONT, '1);
		send_item(CMD_PUSH_BACK, '0);
		send_item(CMD_NONE, 32'sh5555_5555);
		send_item(CMD_POP_BACK, '1);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_PUSH_BACK, 32'shaaaa_aaaa);
		send_item(CMD_PUSH_FRONT, 32'sh5555_5555);
		send_item(CMD_POP_FRONT, rand_word());
		send_item(CMD_POP_BACK, rand_word());
		send_item(CMD_POP_FRONT, rand_word());
		// last word leaves by the back, then both ends see empty again
		send_item(CMD_POP_BACK, rand_word());
		send_item(CMD_POP_FRONT, rand_word());
		send_item(CMD_POP_BACK, rand_word());
		send_item(CMD_PUSH_BACK, 32'sh0000_0001);
		send_item(CMD_POP_FRONT, 32'sh7fff_ffff);
	endtask

	// random walk around empty: many empty pops, pointer wraps both ways
	task automatic test_near_empty();
		repeat (150) send_item(pick_command(45, 45), rand_word());
	endtask

	// mostly pushes at both ends until the ring is full
	task automatic test_fill_to_full();
		while (ring_fill < DEPTH)
			send_item(pick_command(92, 6), rand_word());
	endtask

	// hover at the top: pushes on full get dropped, pops reopen room
	task automatic test_hover_full();
		repeat (80) send_item(pick_command(60, 35), rand_word());
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_results_drained();
		test_near_empty();
		wait_results_drained();
		test_fill_to_full();
		test_hover_full();

		wait_results_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("double_ended_queue regression: pass");
		else
			$display("double_ended_queue regression: fail");
		$finish;
	end

endmodule

### double_ended_queue.f
+incdir+design
design/dq_pkg.sv
design/dq_datapath.sv
design/dq_controller.sv
design/double_ended_queue.sv
dv/double_ended_queue_test.sv
